FILE: hdl/mmsq_pkg.sv
// mmsq_pkg: types, codes and constants of the midi message slot queue
// depends on nothing; imported by mmsq_ram users and the top level
package mmsq_pkg;

  localparam int SLOTS          = 16;
  localparam int MAX_DATA_BYTES = 2;

  localparam int PTR_W   = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(MAX_DATA_BYTES + 1);
  localparam int DDEPTH  = SLOTS * MAX_DATA_BYTES;
  localparam int DADDR_W = (DDEPTH > 1) ? $clog2(DDEPTH) : 1;
  localparam int SLOT_W  = 4;

  typedef enum logic [2:0] {
    ACT_OPEN     = 3'd0,
    ACT_APPEND   = 3'd1,
    ACT_FINISH   = 3'd2,
    ACT_REALTIME = 3'd3,
    ACT_TX_READY = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    OUT_ACCEPTED  = 3'd0,
    OUT_OPENED    = 3'd1,
    OUT_BYTE_SENT = 3'd2,
    OUT_TX_IDLE   = 3'd3,
    OUT_FULL      = 3'd4,
    OUT_RT_IGNORE = 3'd5
  } outcome_t;

  typedef enum logic [1:0] {
    SS_EMPTY     = 2'd0,
    SS_RECEIVING = 2'd1,
    SS_TRANSMIT  = 2'd2,
    SS_DISCARD   = 2'd3
  } slot_state_t;

  typedef enum logic [1:0] {
    CFG_NORMAL_DROP   = 2'd0,
    CFG_REALTIME_DROP = 2'd1,
    CFG_DISCARD_FLAG  = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT
  } fsm_t;

  typedef struct packed {
    logic [2:0]        action;
    logic [SLOT_W-1:0] slot;
    logic [7:0]        msg_flags;
    logic [7:0]        byte_value;
  } cmd_t;

  typedef struct packed {
    logic [2:0]        outcome;
    logic [SLOT_W-1:0] slot_out;
    logic [7:0]        tx_byte;
    logic              last_byte;
  } result_t;

  // one slot record as stored in the record memory
  typedef struct packed {
    logic [1:0]       state;
    logic [7:0]       flags;
    logic [7:0]       status;
    logic [CNT_W-1:0] count;
  } slot_rec_t;

  localparam int REC_W = $bits(slot_rec_t);

  function automatic logic [PTR_W-1:0] ring_next(logic [PTR_W-1:0] p);
    return (int'(p) == SLOTS - 1) ? '0 : PTR_W'(int'(p) + 1);
  endfunction

  function automatic logic [DADDR_W-1:0] data_addr(logic [PTR_W-1:0] p,
                                                   logic [CNT_W-1:0] k);
    return DADDR_W'(int'(p) * MAX_DATA_BYTES + int'(k));
  endfunction

endpackage

FILE: hdl/mmsq_ram.sv
// mmsq_ram: generic single write port, single read port ram
// registered read; no package dependencies
module mmsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/midi_message_slot_queue.sv
// midi_message_slot_queue: ring of message slots feeding a byte-serial transmitter
// depends on mmsq_pkg and mmsq_ram (slot record memory and data byte memory)
//
// one item at a time: an item is taken when start is high and busy is low, and
// its single result shows on result for exactly one cycle with done high; the
// receiver cannot stall, so results must be taken as they appear. open,
// realtime add and unknown actions give their result straight from the issue
// state, and so does a transmit ready tick on an empty ring with no message in
// flight. append, finish and any other transmit ready tick read the slot record
// memory first and give their result from the wait state; a transmit ready tick
// that scans past discarded slots stays in the wait state for each skipped slot
// (a full ring holds SLOTS - 1 slots), since each step of the scan waits on the
// registered read of the record memory. configuration writes are always taken
// (cfg_ready is tied high) and must only be issued while the block is idle.
module midi_message_slot_queue
  import mmsq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // item channel
  input  logic       start,
  output logic       busy,
  input  cmd_t       cmd,
  // result channel
  output logic       done,
  output result_t    result,
  // configuration channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  // configuration registers
  logic [7:0] normal_drop_mask;
  logic [7:0] realtime_drop_mask;
  logic [7:0] discard_flag_mask;

  // ring control
  fsm_t             state, state_next;
  logic [PTR_W-1:0] head, head_next;
  logic [PTR_W-1:0] tail, tail_next;
  logic             sending, sending_next;
  logic [CNT_W-1:0] send_pos, send_pos_next;
  cmd_t             cmd_q;

  // result register
  logic    done_next;
  result_t result_next;

  // memory ports
  logic               rec_we;
  logic [PTR_W-1:0]   rec_waddr;
  slot_rec_t          rec_wdata;
  logic [PTR_W-1:0]   rec_raddr;
  slot_rec_t          rec_rdata;
  logic [REC_W-1:0]   rec_rdata_raw;
  logic               dat_we;
  logic [DADDR_W-1:0] dat_waddr;
  logic [7:0]         dat_wdata;
  logic [DADDR_W-1:0] dat_raddr;
  logic [7:0]         dat_rdata;

  // helpers
  logic [PTR_W-1:0] slot_ptr;
  logic             slot_ok;
  logic             ring_full;
  logic [7:0]       fin_flags;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);
  assign rec_rdata = slot_rec_t'(rec_rdata_raw);
  assign slot_ptr  = PTR_W'(cmd_q.slot);
  assign slot_ok   = ((SLOT_W + 1)'(cmd_q.slot) < (SLOT_W + 1)'(SLOTS));
  assign ring_full = (ring_next(head) == tail);
  assign fin_flags = rec_rdata.flags | cmd_q.msg_flags;

  // slot records: state, flags, status byte, data count
  mmsq_ram #(
    .WIDTH (REC_W),
    .DEPTH (SLOTS)
  ) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (rec_waddr),
    .wdata (rec_wdata),
    .raddr (rec_raddr),
    .rdata (rec_rdata_raw)
  );

  // data bytes, MAX_DATA_BYTES per slot
  mmsq_ram #(
    .WIDTH (8),
    .DEPTH (DDEPTH)
  ) u_dat_ram (
    .clk   (clk),
    .we    (dat_we),
    .waddr (dat_waddr),
    .wdata (dat_wdata),
    .raddr (dat_raddr),
    .rdata (dat_rdata)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      normal_drop_mask   <= 8'd0;
      realtime_drop_mask <= 8'd3;
      discard_flag_mask  <= 8'd128;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NORMAL_DROP:   normal_drop_mask   <= cfg_data;
        CFG_REALTIME_DROP: realtime_drop_mask <= cfg_data;
        CFG_DISCARD_FLAG:  discard_flag_mask  <= cfg_data;
        default: ;  // index beyond the register list is dropped
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head     <= '0;
      tail     <= '0;
      sending  <= 1'b0;
      send_pos <= '0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      head     <= head_next;
      tail     <= tail_next;
      sending  <= sending_next;
      send_pos <= send_pos_next;
      done     <= done_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_q <= cmd;
    end
    result <= result_next;
  end

  // sequencer: issue reads, wait for the registered data, modify and write back.
  // only one item is in flight, so a write back is always seen by the next read
  always_comb begin
    state_next    = state;
    head_next     = head;
    tail_next     = tail;
    sending_next  = sending;
    send_pos_next = send_pos;
    done_next     = 1'b0;
    result_next   = '0;

    rec_we    = 1'b0;
    rec_waddr = head;
    rec_wdata = '0;
    rec_raddr = tail;
    dat_we    = 1'b0;
    dat_waddr = '0;
    dat_wdata = cmd_q.byte_value;
    // data byte of the message in flight: byte send_pos - 1 of the tail slot
    dat_raddr = data_addr(tail, send_pos - CNT_W'(1));

    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_ISSUE;
        end
      end

      S_ISSUE: begin
        case (cmd_q.action)
          ACT_OPEN: begin
            state_next = S_IDLE;
            done_next  = 1'b1;
            if (ring_full) begin
              result_next.outcome = OUT_FULL;
            end else begin
              rec_we               = 1'b1;
              rec_wdata.state      = SS_RECEIVING;
              rec_wdata.flags      = cmd_q.msg_flags;
              rec_wdata.status     = cmd_q.byte_value;
              rec_wdata.count      = '0;
              head_next            = ring_next(head);
              result_next.outcome  = OUT_OPENED;
              result_next.slot_out = SLOT_W'(head);
            end
          end

          ACT_REALTIME: begin
            state_next = S_IDLE;
            done_next  = 1'b1;
            if ((cmd_q.msg_flags & realtime_drop_mask) != 8'd0) begin
              result_next.outcome = OUT_RT_IGNORE;
            end else if (ring_full) begin
              result_next.outcome = OUT_FULL;
            end else begin
              // opened and finished in one go
              rec_we           = 1'b1;
              rec_wdata.state  = ((cmd_q.msg_flags & discard_flag_mask) != 8'd0)
                                 ? SS_DISCARD : SS_TRANSMIT;
              rec_wdata.flags  = cmd_q.msg_flags;
              rec_wdata.status = cmd_q.byte_value;
              rec_wdata.count  = '0;
              head_next        = ring_next(head);
              result_next.outcome  = OUT_ACCEPTED;
              result_next.slot_out = SLOT_W'(head);
            end
          end

          ACT_APPEND, ACT_FINISH: begin
            if (slot_ok) begin
              rec_raddr  = slot_ptr;
              state_next = S_WAIT;
            end else begin
              state_next          = S_IDLE;
              done_next           = 1'b1;
              result_next.outcome = OUT_ACCEPTED;
            end
          end

          ACT_TX_READY: begin
            if (!sending && tail == head) begin
              state_next          = S_IDLE;
              done_next           = 1'b1;
              result_next.outcome = OUT_TX_IDLE;
            end else begin
              // record at tail and, when mid-message, its next data byte
              rec_raddr  = tail;
              state_next = S_WAIT;
            end
          end

          default: begin
            // unknown action: no change
            state_next          = S_IDLE;
            done_next           = 1'b1;
            result_next.outcome = OUT_ACCEPTED;
          end
        endcase
      end

      S_WAIT: begin
        case (cmd_q.action)
          ACT_APPEND: begin
            state_next          = S_IDLE;
            done_next           = 1'b1;
            result_next.outcome = OUT_ACCEPTED;
            // bytes past the limit are dropped
            if (rec_rdata.count < CNT_W'(MAX_DATA_BYTES)) begin
              dat_we          = 1'b1;
              dat_waddr       = data_addr(slot_ptr, rec_rdata.count);
              rec_we          = 1'b1;
              rec_waddr       = slot_ptr;
              rec_wdata       = rec_rdata;
              rec_wdata.count = rec_rdata.count + CNT_W'(1);
            end
          end

          ACT_FINISH: begin
            state_next          = S_IDLE;
            done_next           = 1'b1;
            result_next.outcome = OUT_ACCEPTED;
            rec_we              = 1'b1;
            rec_waddr           = slot_ptr;
            rec_wdata           = rec_rdata;
            rec_wdata.flags     = fin_flags;
            rec_wdata.state     = ((fin_flags & normal_drop_mask) != 8'd0 ||
                                   (fin_flags & discard_flag_mask) != 8'd0)
                                  ? SS_DISCARD : SS_TRANSMIT;
          end

          default: begin
            // transmit ready
            if (sending) begin
              state_next            = S_IDLE;
              done_next             = 1'b1;
              result_next.outcome   = OUT_BYTE_SENT;
              result_next.slot_out  = SLOT_W'(tail);
              result_next.tx_byte   = dat_rdata;
              if (send_pos >= rec_rdata.count) begin
                result_next.last_byte = 1'b1;
                sending_next          = 1'b0;
                send_pos_next         = '0;
                tail_next             = ring_next(tail);
              end else begin
                send_pos_next = send_pos + CNT_W'(1);
              end
            end else begin
              case (rec_rdata.state)
                SS_TRANSMIT: begin
                  // start a new message with its status byte
                  state_next           = S_IDLE;
                  done_next            = 1'b1;
                  result_next.outcome  = OUT_BYTE_SENT;
                  result_next.slot_out = SLOT_W'(tail);
                  result_next.tx_byte  = rec_rdata.status;
                  if (rec_rdata.count == '0) begin
                    result_next.last_byte = 1'b1;
                    tail_next             = ring_next(tail);
                  end else begin
                    sending_next  = 1'b1;
                    send_pos_next = CNT_W'(1);
                  end
                end
                SS_RECEIVING: begin
                  // oldest message still arriving: wait for it
                  state_next          = S_IDLE;
                  done_next           = 1'b1;
                  result_next.outcome = OUT_TX_IDLE;
                end
                default: begin
                  // discarded or empty slot: skip and read the next one
                  tail_next = ring_next(tail);
                  rec_raddr = ring_next(tail);
                  if (ring_next(tail) == head) begin
                    state_next          = S_IDLE;
                    done_next           = 1'b1;
                    result_next.outcome = OUT_TX_IDLE;
                  end
                end
              endcase
            end
          end
        endcase
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // a result only follows a busy state, that is work on an item
  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) != S_IDLE)
    else $error("result strobe without an item in flight");

  // a message in flight has already sent its status byte
  a_send_pos: assert property (@(posedge clk) disable iff (rst)
    sending |-> send_pos != '0)
    else $error("sending with send position zero");

  // the last byte of a message moves the tail on
  a_last_moves_tail: assert property (@(posedge clk) disable iff (rst)
    (done && result.last_byte) |-> tail != $past(tail))
    else $error("last byte sent but tail did not advance");

  // memories are only written while an item is in work
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!rec_we && !dat_we))
    else $error("memory write while idle");

endmodule
